### rtl/sphere_texture_lambert_shade_assert.svh
// assertion macros for the sphere texture lambert shading block
// used by the top level, no other dependencies
`ifndef SPHERE_TEXTURE_LAMBERT_SHADE_ASSERT_SVH
`define SPHERE_TEXTURE_LAMBERT_SHADE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STLS_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stls assertion failed");
`define STLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stls assertion failed");
`else
`define STLS_ASSERT(label, clk, rstn, ante, cons)
`define STLS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/stls_pkg.sv
// shared types, constants and the cordic arctangent table
// no dependencies
`default_nettype none
package stls_pkg;

    localparam int TEX_MAX_WIDTH_DEF  = 256;
    localparam int TEX_MAX_HEIGHT_DEF = 256;
    localparam int WRAP_OFFSET_DEF    = 20;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam int STORE_AW    = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int CFG_DW      = 9;
    localparam int TAB_LEN     = 24;
    localparam int PI_UNITS    = 65536;
    localparam int XW          = 28;
    localparam int AW          = 20;
    localparam int ACC_W       = 24;
    localparam logic [28:0] RECIP_255 = 29'd269488144;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FIRST = 2'd1;
    localparam logic [1:0] CMD_ACC   = 2'd2;

    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        texel_index;
        logic [23:0]        texel_rgb;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        lambert;
        logic [47:0]        light_rgb;
        logic [47:0]        shadow_rgb;
        logic [23:0]        diffuse_rgb;
        logic               is_sphere;
    } in_item_t;

    typedef struct packed {
        logic [23:0] color_red;
        logic [23:0] color_green;
        logic [23:0] color_blue;
        logic [7:0]  texel_column;
        logic [7:0]  texel_row;
    } out_item_t;

    typedef struct packed {
        logic                 valid;
        logic                 bypass;
        logic signed [AW-1:0] base;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] zs;
        logic signed [AW-1:0] ang;
    } cordic_state_t;

    function automatic logic signed [AW-1:0] atan_entry(input int idx);
        logic signed [AW-1:0] val;
        case (idx)
            0:       val = AW'(16384);
            1:       val = AW'(9672);
            2:       val = AW'(5110);
            3:       val = AW'(2594);
            4:       val = AW'(1302);
            5:       val = AW'(652);
            6:       val = AW'(326);
            7:       val = AW'(163);
            8:       val = AW'(81);
            9:       val = AW'(41);
            10:      val = AW'(20);
            11:      val = AW'(10);
            12:      val = AW'(5);
            13:      val = AW'(3);
            14:      val = AW'(1);
            15:      val = AW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

### rtl/stls_cordic_cell.sv
// one vectoring cordic iteration with a fixed shift, registered
// depends on stls_pkg
`default_nettype none
module stls_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stls_pkg::cordic_state_t in_st,
    output stls_pkg::cordic_state_t out_st
);
    import stls_pkg::*;

    cordic_state_t        st_next;
    cordic_state_t        st_reg;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dz;

    always_comb begin
        st_next = in_st;
        dx = in_st.zs >>> SHIFT;
        dz = in_st.xs >>> SHIFT;
        if (!in_st.zs[XW-1]) begin
            st_next.xs  = in_st.xs + dx;
            st_next.zs  = in_st.zs - dz;
            st_next.ang = in_st.ang + atan_entry(SHIFT);
        end else begin
            st_next.xs  = in_st.xs - dx;
            st_next.zs  = in_st.zs + dz;
            st_next.ang = in_st.ang - atan_entry(SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else begin
            st_reg <= st_next;
        end
    end

    assign out_st = st_reg;

endmodule
`default_nettype wire

### rtl/stls_cordic_chain.sv
// atan2 as a row of cordic cells with half-plane reflection and clamping
// depends on stls_pkg and stls_cordic_cell
`default_nettype none
module stls_cordic_chain #(
    parameter int STEPS = stls_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic signed [15:0]             in_z,
    input  logic signed [15:0]             in_x,
    output logic                           out_valid,
    output logic signed [stls_pkg::AW-1:0] out_ang
);
    import stls_pkg::*;

    localparam logic signed [AW-1:0] PI_POS = AW'(PI_UNITS);
    localparam logic signed [AW-1:0] PI_NEG = -AW'(PI_UNITS);

    cordic_state_t        st [STEPS+1];
    cordic_state_t        pre_next;
    cordic_state_t        pre_reg;
    logic signed [16:0]   xe;
    logic signed [16:0]   ze;
    logic signed [16:0]   xr;
    logic signed [16:0]   zr;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] ang_next;
    logic signed [AW-1:0] ang_reg;
    logic                 valid_reg;

    always_comb begin
        xe = 17'(in_x);
        ze = 17'(in_z);
        pre_next = '0;
        if (in_x[15]) begin
            xr = -xe;
            zr = -ze;
            pre_next.base = (zr <= 0) ? PI_POS : PI_NEG;
        end else begin
            xr = xe;
            zr = ze;
        end
        pre_next.valid  = in_valid;
        pre_next.bypass = (zr == 0);
        pre_next.xs     = XW'(xr) <<< 8;
        pre_next.zs     = XW'(zr) <<< 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg.valid <= 1'b0;
        end else begin
            pre_reg <= pre_next;
        end
    end

    assign st[0] = pre_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        stls_cordic_cell #(
            .SHIFT (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .in_st   (st[k]),
            .out_st  (st[k+1])
        );
    end

    always_comb begin
        sum = st[STEPS].ang + st[STEPS].base;
        if (st[STEPS].bypass) begin
            ang_next = st[STEPS].base;
        end else if (sum > PI_POS) begin
            ang_next = PI_POS;
        end else if (sum < PI_NEG) begin
            ang_next = PI_NEG;
        end else begin
            ang_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= st[STEPS].valid;
        end
        ang_reg <= ang_next;
    end

    assign out_valid = valid_reg;
    assign out_ang   = ang_reg;

endmodule
`default_nettype wire

### rtl/stls_isqrt.sv
// floor integer square root, two result bits per cycle pair
// no dependencies beyond the package import style
`default_nettype none
module stls_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [28:0] n_in,
    output logic        busy,
    output logic [14:0] root
);
    localparam int SQ_W = 31;

    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] sq_bit_reg;
    logic [SQ_W-1:0] n_next;
    logic [SQ_W-1:0] res_next;
    logic [SQ_W-1:0] trial;
    logic            busy_reg;

    always_comb begin
        trial = res_reg + sq_bit_reg;
        if (n_reg >= trial) begin
            n_next   = n_reg - trial;
            res_next = (res_reg >> 1) + sq_bit_reg;
        end else begin
            n_next   = n_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            n_reg      <= SQ_W'(n_in);
            res_reg    <= '0;
            sq_bit_reg <= SQ_W'(1) << (SQ_W - 1);
            busy_reg   <= 1'b1;
        end else if (busy_reg) begin
            n_reg      <= n_next;
            res_reg    <= res_next;
            sq_bit_reg <= sq_bit_reg >> 2;
            if (sq_bit_reg == SQ_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[14:0];

endmodule
`default_nettype wire

### rtl/stls_wrap_mod.sv
// remainder of a small value by a run-time modulus, one quotient bit per cycle
// no dependencies
`default_nettype none
module stls_wrap_mod #(
    parameter int VW = 9,
    parameter int MW = 9
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [VW-1:0] value,
    input  logic [MW-1:0] modulus,
    output logic          busy,
    output logic [MW-1:0] result
);
    localparam int KW = $clog2(VW);
    localparam int CW = VW + MW;

    logic [VW-1:0] rem_reg;
    logic [MW-1:0] mod_reg;
    logic [KW-1:0] k_reg;
    logic          busy_reg;
    logic [CW-1:0] cand;
    logic [VW-1:0] rem_next;

    always_comb begin
        cand = CW'(mod_reg) << k_reg;
        if (CW'(rem_reg) >= cand) begin
            rem_next = rem_reg - VW'(cand);
        end else begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            rem_reg  <= value;
            mod_reg  <= modulus;
            k_reg    <= KW'(VW - 1);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            k_reg   <= k_reg - 1'b1;
            if (k_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign result = rem_reg[MW-1:0];

endmodule
`default_nettype wire

### rtl/sphere_texture_lambert_shade.sv
// sphere texture lookup with lambert shading and saturating accumulation
// depends on stls_pkg, stls_cordic_chain, stls_isqrt, stls_wrap_mod
//
// input channel s_valid/s_ready/s_data carries write-texel and shade commands;
// result channel m_valid/m_ready/m_data gives one accumulated color per shade.
// cfg_valid/cfg_ready/cfg_index/cfg_data sets texture width and height;
// cfg_ready is always high and writes belong only to idle periods.
// a texel write gives no result. a diffuse shade goes from idle through S_MUL1,
// S_MUL2, S_MUL3 and S_FIN, where its result is loaded. a sphere shade runs two
// passes through the cordic cell row (the square root overlaps the first), two
// wrap remainders each with their multiply, then addressing, texture read and
// color multiply. one item is in work at a time; s_ready is high only while
// idle, so the next item can be taken in the cycle after the result is loaded.
// the result sits in an output register: a new item is taken while it
// waits, and a finished shade waits for that register to drain when the
// receiver stalls. reset clears the accumulators and sets width and height
// to 256; the texture store is not cleared and holds garbage until written.
`default_nettype none
`include "sphere_texture_lambert_shade_assert.svh"
module sphere_texture_lambert_shade #(
    parameter int TEX_MAX_WIDTH  = stls_pkg::TEX_MAX_WIDTH_DEF,
    parameter int TEX_MAX_HEIGHT = stls_pkg::TEX_MAX_HEIGHT_DEF,
    parameter int WRAP_OFFSET    = stls_pkg::WRAP_OFFSET_DEF,
    parameter int CORDIC_STEPS   = stls_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  stls_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output stls_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [stls_pkg::CFG_DW-1:0]   cfg_data
);
    import stls_pkg::*;

    localparam int WW  = $clog2(TEX_MAX_WIDTH + 1);
    localparam int HW  = $clog2(TEX_MAX_HEIGHT + 1);
    localparam int MXW = (WW > HW) ? WW : HW;
    localparam int VW  = ((MXW > 8) ? MXW : 8) + 1;
    localparam int PW  = (WW + HW > STORE_AW) ? WW + HW : STORE_AW;
    localparam logic signed [15:0] NORM_ONE = 16'sd16384;
    localparam int ONE_SQ = 268435456;

    typedef enum logic [3:0] {
        S_IDLE, S_ATAN, S_SQRT, S_ACOS, S_COLMUL, S_COLMOD, S_ROWMUL, S_ROWMOD,
        S_ADDR, S_READ, S_TEX, S_MUL1, S_MUL2, S_MUL3, S_FIN
    } state_t;

    state_t               state_reg;
    in_item_t             item_reg;
    out_item_t            out_reg;
    logic                 m_valid_reg;
    logic [CFG_DW-1:0]    tex_w_reg;
    logic [CFG_DW-1:0]    tex_h_reg;
    logic [WW-1:0]        w_eff;
    logic [HW-1:0]        h_eff;
    logic signed [15:0]   yc;
    logic signed [15:0]   yc_reg;
    logic signed [31:0]   ysq;
    logic [28:0]          sqrt_n;
    logic                 accept;
    logic                 shade_cmd;
    logic                 sqrt_start;
    logic                 sqrt_busy;
    logic [14:0]          sqrt_root;
    logic                 chain_start;
    logic signed [15:0]   chain_z;
    logic signed [15:0]   chain_x;
    logic                 chain_out_valid;
    logic signed [AW-1:0] chain_out_ang;
    logic signed [AW-1:0] a_reg;
    logic [16:0]          b_reg;
    logic [17:0]          ap;
    logic [18+WW-1:0]     cprod;
    logic [17+HW-1:0]     bprod;
    logic [VW-1:0]        colv_reg;
    logic [VW-1:0]        rowv_reg;
    logic                 mod_go_reg;
    logic                 mod_busy;
    logic [VW-1:0]        mod_value;
    logic [MXW-1:0]       mod_modulus;
    logic [MXW-1:0]       mod_result;
    logic [WW-1:0]        col_reg;
    logic [HW-1:0]        row_reg;
    logic [PW-1:0]        addr_full;
    logic [STORE_AW-1:0]  addr_reg;
    logic [23:0]          tex_mem [STORE_DEPTH];
    logic [23:0]          rd_reg;
    logic [23:0]          rgb_reg;
    logic [23:0]          p1_reg  [3];
    logic [31:0]          p2_reg  [3];
    logic [27:0]          q_reg   [3];
    logic [20:0]          est_reg [3];
    logic [ACC_W-1:0]     acc_reg [3];
    logic [55:0]          prod    [3];
    logic [56:0]          rprod   [3];
    logic [28:0]          mul255  [3];
    logic [28:0]          rem     [3];
    logic [20:0]          add     [3];
    logic [ACC_W:0]       sum     [3];
    logic [ACC_W-1:0]     acc_next[3];
    logic                 out_free;
    logic [15:0]          col_x;
    logic [15:0]          row_x;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign accept    = s_valid && s_ready;
    assign shade_cmd = (s_data.command == CMD_FIRST) || (s_data.command == CMD_ACC);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (tex_w_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(tex_w_reg) > TEX_MAX_WIDTH) begin
            w_eff = WW'(TEX_MAX_WIDTH);
        end else begin
            w_eff = WW'(tex_w_reg);
        end
        if (tex_h_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(tex_h_reg) > TEX_MAX_HEIGHT) begin
            h_eff = HW'(TEX_MAX_HEIGHT);
        end else begin
            h_eff = HW'(tex_h_reg);
        end
    end

    always_comb begin
        if (s_data.normal_y > NORM_ONE) begin
            yc = NORM_ONE;
        end else if (s_data.normal_y < -NORM_ONE) begin
            yc = -NORM_ONE;
        end else begin
            yc = s_data.normal_y;
        end
        ysq    = yc * yc;
        sqrt_n = 29'(ONE_SQ - ysq);
    end

    assign sqrt_start  = accept && shade_cmd && s_data.is_sphere;
    assign chain_start = sqrt_start || ((state_reg == S_SQRT) && !sqrt_busy);
    assign chain_z     = (state_reg == S_IDLE) ? s_data.normal_z : signed'({1'b0, sqrt_root});
    assign chain_x     = (state_reg == S_IDLE) ? s_data.normal_x : yc_reg;

    stls_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .n_in    (sqrt_n),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    stls_cordic_chain #(
        .STEPS (CORDIC_STEPS)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_start),
        .in_z      (chain_z),
        .in_x      (chain_x),
        .out_valid (chain_out_valid),
        .out_ang   (chain_out_ang)
    );

    assign mod_value   = (state_reg == S_ROWMOD) ? rowv_reg : colv_reg;
    assign mod_modulus = (state_reg == S_ROWMOD) ? MXW'(h_eff) : MXW'(w_eff);

    stls_wrap_mod #(
        .VW (VW),
        .MW (MXW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_go_reg),
        .value   (mod_value),
        .modulus (mod_modulus),
        .busy    (mod_busy),
        .result  (mod_result)
    );

    assign ap        = 18'(a_reg + AW'(PI_UNITS));
    assign cprod     = (18 + WW)'(ap) * (18 + WW)'(w_eff);
    assign bprod     = (17 + HW)'(b_reg) * (17 + HW)'(h_eff);
    assign addr_full = PW'(row_reg) * PW'(w_eff) + PW'(col_reg);
    assign col_x     = 16'(col_reg);
    assign row_x     = 16'(row_reg);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch]   = 56'(p1_reg[ch]) * 56'(p2_reg[ch]);
            rprod[ch]  = 57'(q_reg[ch]) * 57'(RECIP_255);
            mul255[ch] = {est_reg[ch], 8'b0} - 29'(est_reg[ch]);
            rem[ch]    = 29'(q_reg[ch]) - mul255[ch];
            add[ch]    = est_reg[ch] + 21'(rem[ch] >= 29'd255);
            sum[ch]    = ((item_reg.command == CMD_FIRST) ? '0 : (ACC_W + 1)'(acc_reg[ch]))
                         + (ACC_W + 1)'(add[ch]);
            acc_next[ch] = sum[ch][ACC_W] ? '1 : sum[ch][ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_data.command == CMD_WRITE)) begin
            tex_mem[s_data.texel_index] <= s_data.texel_rgb;
        end
        rd_reg <= tex_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            mod_go_reg  <= 1'b0;
            tex_w_reg   <= CFG_DW'(256);
            tex_h_reg   <= CFG_DW'(256);
            for (int ch = 0; ch < 3; ch++) begin
                acc_reg[ch] <= '0;
            end
        end else begin
            mod_go_reg <= (state_reg == S_COLMUL) || (state_reg == S_ROWMUL);
            if (cfg_valid) begin
                if (cfg_index == CFG_TEX_WIDTH) begin
                    tex_w_reg <= cfg_data;
                end else begin
                    tex_h_reg <= cfg_data;
                end
            end
            if ((state_reg == S_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && shade_cmd) begin
                        item_reg <= s_data;
                        yc_reg   <= yc;
                        if (s_data.is_sphere) begin
                            state_reg <= S_ATAN;
                        end else begin
                            rgb_reg   <= s_data.diffuse_rgb;
                            col_reg   <= '0;
                            row_reg   <= '0;
                            state_reg <= S_MUL1;
                        end
                    end
                end
                S_ATAN: begin
                    if (chain_out_valid) begin
                        a_reg     <= chain_out_ang;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (!sqrt_busy) begin
                        state_reg <= S_ACOS;
                    end
                end
                S_ACOS: begin
                    if (chain_out_valid) begin
                        b_reg     <= chain_out_ang[AW-1] ? '0 : 17'(chain_out_ang);
                        state_reg <= S_COLMUL;
                    end
                end
                S_COLMUL: begin
                    colv_reg   <= VW'(cprod >> 17) + VW'(WRAP_OFFSET);
                    state_reg  <= S_COLMOD;
                end
                S_COLMOD: begin
                    if (!mod_go_reg && !mod_busy) begin
                        col_reg   <= WW'(mod_result);
                        state_reg <= S_ROWMUL;
                    end
                end
                S_ROWMUL: begin
                    rowv_reg   <= VW'(bprod >> 16) + VW'(WRAP_OFFSET);
                    state_reg  <= S_ROWMOD;
                end
                S_ROWMOD: begin
                    if (!mod_go_reg && !mod_busy) begin
                        row_reg   <= HW'(mod_result);
                        state_reg <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    addr_reg  <= addr_full[STORE_AW-1:0];
                    state_reg <= S_READ;
                end
                S_READ: begin
                    state_reg <= S_TEX;
                end
                S_TEX: begin
                    rgb_reg   <= rd_reg;
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        p1_reg[ch] <= 24'(rgb_reg[8*(2-ch) +: 8])
                                      * 24'(item_reg.light_rgb[16*(2-ch) +: 16]);
                        p2_reg[ch] <= 32'(item_reg.lambert)
                                      * 32'(item_reg.shadow_rgb[16*(2-ch) +: 16]);
                    end
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        q_reg[ch] <= prod[ch][55:28];
                    end
                    state_reg <= S_MUL3;
                end
                S_MUL3: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        est_reg[ch] <= rprod[ch][56:36];
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            acc_reg[ch] <= acc_next[ch];
                        end
                        out_reg.color_red    <= acc_next[0];
                        out_reg.color_green  <= acc_next[1];
                        out_reg.color_blue   <= acc_next[2];
                        out_reg.texel_column <= col_x[7:0];
                        out_reg.texel_row    <= row_x[7:0];
                        state_reg            <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `STLS_ASSERT(a_chain_expected, aclk, aresetn, chain_out_valid, (state_reg == S_ATAN) || (state_reg == S_ACOS))
    `STLS_ASSERT(a_sqrt_done, aclk, aresetn, state_reg == S_ACOS, !sqrt_busy)
    `STLS_ASSERT_NEXT(a_result_loaded, aclk, aresetn, (state_reg == S_FIN) && out_free, m_valid_reg && (state_reg == S_IDLE))
    `STLS_ASSERT_NEXT(a_write_silent, aclk, aresetn, accept && (s_data.command == CMD_WRITE) && !m_valid_reg, !m_valid_reg)

endmodule
`default_nettype wire

### tb/sphere_texture_lambert_shade_tb.sv
// self-checking testbench for sphere_texture_lambert_shade: directed table then random traffic
// depends on stls_pkg and the sphere_texture_lambert_shade rtl
`timescale 1ns / 1ps
module sphere_texture_lambert_shade_tb;
    import stls_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [CFG_DW-1:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    sphere_texture_lambert_shade u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [23:0] texels [0:65535];
    bit written [0:65535];
    logic [23:0] acc_r, acc_g, acc_b;
    int unsigned width_reg, height_reg;
    out_item_t expected_colors [$];
    int errors = 0;
    bit stall_free = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(input longint z_in, input longint x_in);
        longint x, z, base, ang, xs, zs, dx, dz;
        longint tab [16] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163,
                             81, 41, 20, 10, 5, 3, 1, 1};
        x = x_in; z = z_in; base = 0; ang = 0;
        if (x < 0) begin
            x = -x; z = -z;
            base = (z <= 0) ? 65536 : -65536;
        end
        if (z == 0) return base;
        xs = x * 256; zs = z * 256;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(zs, i); dz = floor_shift(xs, i);
            if (zs >= 0) begin
                xs += dx; zs -= dz; ang += tab[i];
            end else begin
                xs -= dx; zs += dz; ang -= tab[i];
            end
        end
        ang += base;
        if (ang > 65536) ang = 65536;
        if (ang < -65536) ang = -65536;
        return ang;
    endfunction

    function automatic longint floor_sqrt(input longint n_in);
        longint n, res, b;
        n = n_in; res = 0; b = longint'(1) << 30;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b; res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned eff_size(input int unsigned v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    // texel column, row and store address for a normal
    function automatic void map_normal(input in_item_t it, output int unsigned col,
                                       output int unsigned row, output int unsigned addr);
        int unsigned w, h;
        longint a, b, ny, s;
        w = eff_size(width_reg); h = eff_size(height_reg);
        a = cordic_angle(longint'(it.normal_z), longint'(it.normal_x)) + 65536;
        col = (((a * w) >> 17) + 20) % w;
        ny = it.normal_y;
        if (ny > 16384) ny = 16384;
        if (ny < -16384) ny = -16384;
        s = floor_sqrt(268435456 - ny * ny);
        b = cordic_angle(s, ny);
        if (b < 0) b = 0;
        row = (((b * h) >> 16) + 20) % h;
        addr = (row * w + col) & 16'hFFFF;
    endfunction

    function automatic logic [23:0] add_channel(input logic [23:0] acc, input logic [7:0] c,
            input logic [15:0] li, input logic [15:0] lam, input logic [15:0] sh);
        logic [63:0] prod, add, sum;
        prod = 64'(c) * 64'(li) * 64'(lam) * 64'(sh);
        add = prod / (64'd255 << 28);
        sum = 64'(acc) + add;
        return (sum > 64'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
    endfunction

    function automatic bit shade_predict(input in_item_t it, output out_item_t r);
        int unsigned col, row, addr;
        logic [23:0] rgb;
        r = '0;
        if (it.command == CMD_WRITE) begin
            texels[it.texel_index] = it.texel_rgb;
            written[it.texel_index] = 1'b1;
            return 0;
        end
        if (it.command == CMD_UNUSED) return 0;
        col = 0; row = 0;
        if (it.is_sphere) begin
            map_normal(it, col, row, addr);
            rgb = texels[addr];
        end else rgb = it.diffuse_rgb;
        if (it.command == CMD_FIRST) begin
            acc_r = '0; acc_g = '0; acc_b = '0;
        end
        acc_r = add_channel(acc_r, rgb[23:16], it.light_rgb[47:32], it.lambert,
                            it.shadow_rgb[47:32]);
        acc_g = add_channel(acc_g, rgb[15:8], it.light_rgb[31:16], it.lambert,
                            it.shadow_rgb[31:16]);
        acc_b = add_channel(acc_b, rgb[7:0], it.light_rgb[15:0], it.lambert,
                            it.shadow_rgb[15:0]);
        r.color_red = acc_r; r.color_green = acc_g; r.color_blue = acc_b;
        r.texel_column = col[7:0]; r.texel_row = row[7:0];
        return 1;
    endfunction

    // a sphere shade is legal only if its texel was written
    function automatic bit shade_is_safe(input in_item_t it);
        int unsigned col, row, addr;
        if (it.command == CMD_WRITE || it.command == CMD_UNUSED || !it.is_sphere) return 1;
        map_normal(it, col, row, addr);
        return written[addr];
    endfunction

    // valid stays high between back-to-back items and drops only while idling
    task automatic send_item(input in_item_t it);
        out_item_t r;
        while (!stall_free && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (shade_predict(it, r)) expected_colors.push_back(r);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_colors.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned v);
        s_valid <= 1'b0;
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= CFG_DW'(v);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_TEX_WIDTH) width_reg = v; else height_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // fill the whole used texture area so every sphere read hits a written texel
    task automatic fill_texture();
        in_item_t it;
        int unsigned w, h;
        w = eff_size(width_reg); h = eff_size(height_reg);
        for (int unsigned i = 0; i < w * h; i++) begin
            it = '0;
            it.command = CMD_WRITE;
            it.texel_index = i[15:0];
            it.texel_rgb = ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom);
            send_item(it);
        end
    endtask

    function automatic in_item_t random_shade();
        in_item_t it;
        int k;
        it = '0;
        it.command = ($urandom_range(3) == 0) ? CMD_FIRST : CMD_ACC;
        it.texel_index = 16'($urandom);
        it.texel_rgb = 24'($urandom);
        k = $urandom_range(9);
        it.normal_x = (k == 0) ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
        it.normal_y = (k == 1) ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
        it.normal_z = (k == 2) ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
        if (k == 3) it.normal_z = 16'sd0;
        it.lambert = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom);
        it.light_rgb = {16'($urandom), 16'($urandom), 16'($urandom)};
        it.shadow_rgb = {16'($urandom), 16'($urandom), 16'($urandom)};
        it.diffuse_rgb = 24'($urandom);
        it.is_sphere = $urandom_range(2) != 0;
        return it;
    endfunction

    // result side
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= stall_free || ($urandom_range(99) >= 34);
    end

    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected transfer", m_data, 0);
            end else begin
                e = expected_colors.pop_front();
                if (m_data.color_red !== e.color_red)
                    report_mismatch("color_red", m_data.color_red, e.color_red);
                if (m_data.color_green !== e.color_green)
                    report_mismatch("color_green", m_data.color_green, e.color_green);
                if (m_data.color_blue !== e.color_blue)
                    report_mismatch("color_blue", m_data.color_blue, e.color_blue);
                if (m_data.texel_column !== e.texel_column)
                    report_mismatch("texel_column", m_data.texel_column, e.texel_column);
                if (m_data.texel_row !== e.texel_row)
                    report_mismatch("texel_row", m_data.texel_row, e.texel_row);
            end
        end
    end

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] nx, ny, nz;
        bit          sphere;
        logic [23:0] diffuse;
        logic [15:0] lam;
        logic [47:0] light, shadow;
        bit          has_fixed;
        logic [23:0] fixed_red;
    } dir_row_t;

    dir_row_t dir_rows [] = '{
        '{CMD_ACC, 0, 0, 0, 0, 24'hFFFFFF, 0, {3{16'hFFFF}}, {3{16'hFFFF}}, 1, 24'h0},
        '{CMD_FIRST, 0, 0, 0, 0, 24'hFFFFFF, 16'hFFFF, {3{16'hFFFF}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 0, 0, 0, 24'hFFFFFF, 16'hFFFF, {3{16'hFFFF}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 0, 0, 0, 24'hFFFFFF, 16'hFFFF, {3{16'hFFFF}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 0, 0, 0, 24'hFFFFFF, 16'hFFFF, {3{16'hFFFF}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_FIRST, 0, 0, 0, 0, 24'h000000, 16'hFFFF, {3{16'hFFFF}}, {3{16'hFFFF}}, 1, 24'h0},
        '{CMD_UNUSED, 0, 0, 0, 1, 24'h123456, 16'h1234, 48'h1, 48'h1, 0, 0},
        '{CMD_FIRST, 16'h4000, 0, 0, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 16'hC000, 0, 0, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 16'h4000, 0, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 16'hC000, 0, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 16'h7FFF, 0, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 16'h8000, 0, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 0, 0, 16'h4000, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 16'hC000, 0, 16'hC000, 1, 0, 16'h8000, {3{16'h1000}}, {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 16'h8000, 16'h7FFF, 16'h7FFF, 1, 0, 16'hFFFF, {3{16'hFFFF}},
          {3{16'hFFFF}}, 0, 0},
        '{CMD_ACC, 16'h7FFF, 16'h8000, 16'h8000, 1, 0, 16'hFFFF, 48'h0, 48'h0, 0, 0}
    };

    initial begin
        in_item_t it;
        int unsigned sizes [6] = '{1, 256, 0, 300, 7, 13};
        width_reg = 256; height_reg = 256;
        acc_r = '0; acc_g = '0; acc_b = '0;
        foreach (written[i]) written[i] = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // small texture for the directed rows
        write_reg(CFG_TEX_WIDTH, 5);
        write_reg(CFG_TEX_HEIGHT, 4);
        fill_texture();
        foreach (dir_rows[i]) begin
            it = '0;
            it.command = dir_rows[i].cmd;
            it.normal_x = dir_rows[i].nx; it.normal_y = dir_rows[i].ny;
            it.normal_z = dir_rows[i].nz;
            it.is_sphere = dir_rows[i].sphere;
            it.diffuse_rgb = dir_rows[i].diffuse;
            it.lambert = dir_rows[i].lam;
            it.light_rgb = dir_rows[i].light; it.shadow_rgb = dir_rows[i].shadow;
            send_item(it);
            if (dir_rows[i].has_fixed && expected_colors.size() != 0 &&
                    expected_colors[$].color_red !== dir_rows[i].fixed_red)
                report_mismatch("directed table", expected_colors[$].color_red,
                                dir_rows[i].fixed_red);
        end
        wait_drain();

        // random phases over several texture sizes, extremes included
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_TEX_WIDTH, sizes[p]);
            write_reg(CFG_TEX_HEIGHT, sizes[(p + 3) % 6]);
            if (p == 0) stall_free = 1'b1;
            if (p == 1) stall_free = 1'b0;
            for (int n = 0; n < 255; n++) begin
                if ($urandom_range(19) == 0) begin
                    it = random_shade();
                    it.command = ($urandom_range(1) == 0) ? CMD_WRITE : CMD_UNUSED;
                end else begin
                    do it = random_shade(); while (!shade_is_safe(it));
                end
                if (p != 1 || it.command != CMD_WRITE) send_item(it);
                if (n == 140) wait_drain();
            end
            wait_drain();
            foreach (written[i]) written[i] = 1'b0;
            if (p == 0) begin
                write_reg(CFG_TEX_WIDTH, 9);
                write_reg(CFG_TEX_HEIGHT, 11);
                fill_texture();
                wait_drain();
            end
        end

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
